// ===== rtl/rhv_pkg.sv =====
// Types, codes and constants shared by the raster H/V IRQ timer.
// No dependencies.
package rhv_pkg;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [4:0] REG_CTRL     = 5'd0;
    localparam logic [4:0] REG_HTIME_LO = 5'd7;
    localparam logic [4:0] REG_HTIME_HI = 5'd8;
    localparam logic [4:0] REG_VTIME_LO = 5'd9;
    localparam logic [4:0] REG_VTIME_HI = 5'd10;
    localparam logic [4:0] REG_STATUS   = 5'd17;

    localparam logic [2:0] ACT_NONE         = 3'd0;
    localparam logic [2:0] ACT_ASSERT       = 3'd1;
    localparam logic [2:0] ACT_CLEAR_LINE   = 3'd2;
    localparam logic [2:0] ACT_CANCEL       = 3'd3;
    localparam logic [2:0] ACT_CLEAR_STATUS = 3'd4;

    localparam logic [2:0] HOLD_START     = 3'd4;
    localparam logic [8:0] TARGET_RESET   = 9'h1ff;
    localparam int         CTRL_H_BIT     = 4;
    localparam int         CTRL_V_BIT     = 5;
    localparam logic [7:0] STATUS_FLAG    = 8'h80;

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  line;
        logic [10:0] dot_pos;
        logic [31:0] clock_stamp;
        logic [8:0]  gate_line;
        logic [10:0] gate_dot;
        logic [15:0] elapsed_clocks;
        logic [4:0]  reg_offset;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [8:0]  prev_line;
        logic [10:0] prev_dot;
        logic [31:0] prev_clock;
        logic [8:0]  prev_gate_line;
        logic [10:0] prev_gate_dot;
        logic        cond_valid;
        logic        flag_bit;
        logic [2:0]  hold_count;
        logic [8:0]  h_target;
        logic [8:0]  v_target;
        logic        h_enable;
        logic        v_enable;
    } state_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] line_action;
        logic       flag_now;
    } res_t;

    localparam state_t STATE_RESET = '{
        prev_line: '0, prev_dot: '0, prev_clock: '0,
        prev_gate_line: '0, prev_gate_dot: '0,
        cond_valid: 1'b0, flag_bit: 1'b0, hold_count: '0,
        h_target: TARGET_RESET, v_target: TARGET_RESET,
        h_enable: 1'b0, v_enable: 1'b0
    };

endpackage

// ===== rtl/rhv_eval.sv =====
// Single-pass evaluation of one beat: next timer state and the result.
// Depends on rhv_pkg.
module rhv_eval (
    input  rhv_pkg::state_t state_cur,
    input  rhv_pkg::item_t  item,
    output rhv_pkg::state_t state_nxt,
    output rhv_pkg::res_t   res
);
    import rhv_pkg::*;

    function automatic logic crossed(
        input logic [8:0]  cl,
        input logic [10:0] cd,
        input logic [31:0] cc,
        input logic [8:0]  tl,
        input logic [11:0] td,
        input logic [8:0]  pl,
        input logic [10:0] pd,
        input logic [31:0] pc
    );
        logic r;
        if (cl < pl) begin
            r = (tl >= pl) || ((tl <= cl) && (td <= {1'b0, cd}));
        end else if ((tl < pl) || (tl > cl)) begin
            r = 1'b0;
        end else if ((tl == pl) && (td < {1'b0, pd})) begin
            r = 1'b0;
        end else if ((tl == cl) && (td > {1'b0, cd})) begin
            r = 1'b0;
        end else begin
            r = (pc != cc);
        end
        return r;
    endfunction

    function automatic logic cond_at(
        input logic [8:0]  ln,
        input logic [10:0] dt,
        input logic [8:0]  gl,
        input logic [10:0] gd,
        input logic        hen,
        input logic        ven,
        input logic [8:0]  vt,
        input logic [11:0] tdot
    );
        logic r;
        r = hen || ven;
        if (gl == 9'd0 && gd == 11'd0) r = 1'b0;
        if (ven && ln != vt) r = 1'b0;
        if (hen && {1'b0, dt} != tdot) r = 1'b0;
        return r;
    endfunction

    logic [11:0] tdot_cur;
    logic [11:0] tdot_wr;
    logic [9:0]  ht_inc_cur;
    logic [9:0]  ht_inc_wr;
    logic        gate_open;
    logic        cross_hv;
    logic        cross_h_prev;
    logic        cross_h_cur;
    logic        cross_v;
    logic        edge_hit;
    logic        cond_tick;
    logic        el_covers;
    logic [2:0]  hold_dec;
    logic        hen_w;
    logic        ven_w;
    logic [8:0]  ht_w;
    logic [8:0]  vt_w;
    logic        do_repoll;
    logic        cond_poll;

    assign ht_inc_cur = {1'b0, state_cur.h_target} + 10'd1;
    assign tdot_cur   = {ht_inc_cur, 2'b00};
    assign ht_inc_wr  = {1'b0, ht_w} + 10'd1;
    assign tdot_wr    = {ht_inc_wr, 2'b00};

    assign el_covers = (item.elapsed_clocks >= {13'd0, state_cur.hold_count});
    assign hold_dec  = el_covers ? 3'd0 : (state_cur.hold_count - item.elapsed_clocks[2:0]);

    assign gate_open = (item.gate_line != 9'd0) || (item.gate_dot != 11'd0);

    assign cross_hv = crossed(item.line, item.dot_pos, item.clock_stamp,
                              state_cur.v_target, tdot_cur, state_cur.prev_line,
                              state_cur.prev_dot, state_cur.prev_clock);
    assign cross_h_prev = crossed(item.line, item.dot_pos, item.clock_stamp,
                                  state_cur.prev_line, tdot_cur, state_cur.prev_line,
                                  state_cur.prev_dot, state_cur.prev_clock);
    assign cross_h_cur = crossed(item.line, item.dot_pos, item.clock_stamp,
                                 item.line, tdot_cur, state_cur.prev_line,
                                 state_cur.prev_dot, state_cur.prev_clock);
    assign cross_v = crossed(item.line, item.dot_pos, item.clock_stamp,
                             state_cur.v_target, 12'd0, state_cur.prev_line,
                             state_cur.prev_dot, state_cur.prev_clock);

    always_comb begin
        edge_hit = 1'b0;
        if (gate_open) begin
            if (state_cur.h_enable && state_cur.v_enable) begin
                edge_hit = cross_hv;
            end else if (state_cur.h_enable) begin
                edge_hit = cross_h_prev ||
                           ((item.line != state_cur.prev_line) && cross_h_cur);
            end else if (state_cur.v_enable) begin
                edge_hit = cross_v;
            end
        end
    end

    assign cond_tick = cond_at(item.line, item.dot_pos, item.gate_line, item.gate_dot,
                               state_cur.h_enable, state_cur.v_enable,
                               state_cur.v_target, tdot_cur);

    // register write decode
    always_comb begin
        hen_w     = state_cur.h_enable;
        ven_w     = state_cur.v_enable;
        ht_w      = state_cur.h_target;
        vt_w      = state_cur.v_target;
        do_repoll = 1'b1;
        case (item.reg_offset)
            REG_CTRL: begin
                hen_w = item.write_data[CTRL_H_BIT];
                ven_w = item.write_data[CTRL_V_BIT];
            end
            REG_HTIME_LO: ht_w = {state_cur.h_target[8], item.write_data};
            REG_HTIME_HI: ht_w = {item.write_data[0], state_cur.h_target[7:0]};
            REG_VTIME_LO: vt_w = {state_cur.v_target[8], item.write_data};
            REG_VTIME_HI: vt_w = {item.write_data[0], state_cur.v_target[7:0]};
            default:      do_repoll = 1'b0;
        endcase
    end

    assign cond_poll = cond_at(state_cur.prev_line, state_cur.prev_dot,
                               state_cur.prev_gate_line, state_cur.prev_gate_dot,
                               hen_w, ven_w, vt_w, tdot_wr);

    always_comb begin
        state_nxt       = state_cur;
        res.read_data   = 8'd0;
        res.line_action = ACT_NONE;
        case (item.func)
            FUNC_TICK: begin
                state_nxt.hold_count     = hold_dec;
                if (edge_hit) begin
                    state_nxt.flag_bit   = 1'b1;
                    state_nxt.hold_count = HOLD_START;
                    res.line_action      = ACT_ASSERT;
                end else begin
                    res.line_action      = ACT_CLEAR_LINE;
                end
                state_nxt.prev_line      = item.line;
                state_nxt.prev_dot       = item.dot_pos;
                state_nxt.prev_clock     = item.clock_stamp;
                state_nxt.prev_gate_line = item.gate_line;
                state_nxt.prev_gate_dot  = item.gate_dot;
                state_nxt.cond_valid     = cond_tick;
            end
            FUNC_WRITE: begin
                state_nxt.h_enable = hen_w;
                state_nxt.v_enable = ven_w;
                state_nxt.h_target = ht_w;
                state_nxt.v_target = vt_w;
                if (do_repoll) begin
                    if (!hen_w && !ven_w) begin
                        state_nxt.cond_valid = 1'b0;
                        res.line_action      = ACT_CANCEL;
                    end else begin
                        if (cond_poll && !state_cur.cond_valid) begin
                            state_nxt.flag_bit   = 1'b1;
                            state_nxt.hold_count = HOLD_START;
                            res.line_action      = ACT_ASSERT;
                        end
                        state_nxt.cond_valid = cond_poll;
                    end
                end
            end
            FUNC_READ: begin
                case (item.reg_offset)
                    REG_CTRL: begin
                        res.read_data[CTRL_H_BIT] = state_cur.h_enable;
                        res.read_data[CTRL_V_BIT] = state_cur.v_enable;
                    end
                    REG_HTIME_LO: res.read_data = state_cur.h_target[7:0];
                    REG_HTIME_HI: res.read_data = {7'd0, state_cur.h_target[8]};
                    REG_VTIME_LO: res.read_data = state_cur.v_target[7:0];
                    REG_VTIME_HI: res.read_data = {7'd0, state_cur.v_target[8]};
                    REG_STATUS: begin
                        res.read_data = state_cur.flag_bit ? STATUS_FLAG : 8'd0;
                        if (el_covers) begin
                            state_nxt.flag_bit   = 1'b0;
                            state_nxt.hold_count = 3'd0;
                            res.line_action      = ACT_CLEAR_STATUS;
                        end
                    end
                    default: res.read_data = 8'd0;
                endcase
            end
            default: res.line_action = ACT_NONE;
        endcase
        res.flag_now = state_nxt.flag_bit;
    end

endmodule

// ===== rtl/raster_hv_irq_timer.sv =====
// Raster H/V position IRQ timer: input register, timer state, result register.
// Depends on rhv_pkg and rhv_eval.
//
//  channel | ports                                   | direction
//  s_      | s_valid/s_ready, func, positions, regs  | in  (tick/write/read beat)
//  m_      | m_valid/m_ready, read_data, action,flag | out (one result beat each)
//
// Takes one beat per cycle while m_ready does not stall the output; an accepted
// s_ beat passes the input register, then the result register that drives m_valid.
// The input register feeds rhv_eval, which updates the timer state and loads
// the result register in the same cycle.
// Reset (aresetn low, synchronous) empties both registers and restores the
// timer state. A stalled m_ beat holds the input register; s_ready stays high
// while the input register is empty or moving forward.
module raster_hv_irq_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [8:0]  s_line,
    input  logic [10:0] s_dot_pos,
    input  logic [31:0] s_clock_stamp,
    input  logic [8:0]  s_gate_line,
    input  logic [10:0] s_gate_dot,
    input  logic [15:0] s_elapsed_clocks,
    input  logic [4:0]  s_reg_offset,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [2:0]  m_line_action,
    output logic        m_flag_now
);
    import rhv_pkg::*;

    logic   in_valid_reg;
    item_t  item_reg;
    logic   out_valid_reg;
    res_t   res_reg;
    state_t state_reg;
    state_t state_next;
    res_t   res_next;
    logic   advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rhv_eval u_eval (
        .state_cur (state_reg),
        .item      (item_reg),
        .state_nxt (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{func: s_func, line: s_line, dot_pos: s_dot_pos,
                          clock_stamp: s_clock_stamp, gate_line: s_gate_line,
                          gate_dot: s_gate_dot, elapsed_clocks: s_elapsed_clocks,
                          reg_offset: s_reg_offset, write_data: s_write_data};
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_read_data   = res_reg.read_data;
    assign m_line_action = res_reg.line_action;
    assign m_flag_now    = res_reg.flag_now;

`ifndef SYNTHESIS
    a_hold_needs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.flag_bit |-> state_reg.hold_count == 3'd0)
        else $error("hold count nonzero with flag clear");

    a_hold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hold_count <= HOLD_START)
        else $error("hold count above start value");

    a_assert_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_action == ACT_ASSERT |-> m_flag_now)
        else $error("irq asserted without flag");

    a_clear_drops_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_action == ACT_CLEAR_STATUS |-> !m_flag_now)
        else $error("status cleared but flag still set");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && state_reg == $past(state_next))
        else $error("advanced beat lost");
`endif

endmodule
